/* src/hbdrv_pkg.sv */
// Shared types and constants of the H-bridge drive and steering servo block.
package hbdrv_pkg;

  // Field widths of the stream items
  localparam int unsigned SPEED_W   = 9;
  localparam int unsigned STEER_W   = 2;
  localparam int unsigned CMP_W     = 12;
  localparam int unsigned RELOAD_W  = 16;
  localparam int unsigned TICKS_W   = 8;
  localparam int unsigned MAG_FIELD_W = 8;

  // Packed stream widths (whole bytes)
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 56;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Default for the speed magnitude width
  localparam int unsigned SPEED_BITS_DEF = 8;

  // Command queue depth between front and back
  localparam int unsigned CMD_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SPEED_THR  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEAD_TIME  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HARD_LEFT  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_HARD_RIGHT = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTRE     = 3'd6;

  // Register reset values
  localparam logic [TICKS_W-1:0]  SPEED_THR_RST  = 8'd20;
  localparam logic [TICKS_W-1:0]  DEAD_TIME_RST  = 8'd23;
  localparam logic [RELOAD_W-1:0] LEFT_RST       = 16'd47407;
  localparam logic [RELOAD_W-1:0] HARD_LEFT_RST  = 16'd49407;
  localparam logic [RELOAD_W-1:0] RIGHT_RST      = 16'd37278;
  localparam logic [RELOAD_W-1:0] HARD_RIGHT_RST = 16'd35278;
  localparam logic [RELOAD_W-1:0] CENTRE_RST     = 16'd42843;

  // Request kinds and steering codes
  localparam logic REQ_SPEED = 1'b0;
  localparam logic REQ_STEER = 1'b1;

  localparam logic [STEER_W-1:0] STEER_LEFT   = 2'd0;
  localparam logic [STEER_W-1:0] STEER_RIGHT  = 2'd1;
  localparam logic [STEER_W-1:0] STEER_CENTRE = 2'd2;

  localparam logic [CMP_W-1:0] CMP_MAX = 12'd4095;

  // Classified command handed from front to back
  typedef struct packed {
    logic                     is_steer;
    logic [STEER_W-1:0]       steer;
    logic                     want_rev;
    logic [MAG_FIELD_W-1:0]   mag;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [CMP_W-1:0]    fwd_cmp;
    logic [CMP_W-1:0]    rev_cmp;
    logic                fwd_en;
    logic                rev_en;
    logic [RELOAD_W-1:0] servo;
    logic [TICKS_W-1:0]  hold;
    logic                last;
  } res_t;

endpackage

/* src/hbdrv_front.sv */
// Front end: accepts command items and classifies them into queue entries.
module hbdrv_front import hbdrv_pkg::*; #(
  parameter int unsigned SPEED_BITS = SPEED_BITS_DEF
) (
  input  logic                 req_type_i,
  input  logic [SPEED_W-1:0]   speed_i,
  input  logic [STEER_W-1:0]   steer_i,
  output cmd_t                 cmd_o
);

  localparam int unsigned MAG_W = (SPEED_BITS >= 8) ? 8 : SPEED_BITS;
  localparam logic [SPEED_W-1:0] MAG_LIMIT = SPEED_W'((1 << MAG_W) - 1);

  logic               neg;
  logic [SPEED_W-1:0] abs_val;
  logic [SPEED_W-1:0] mag_sat;

  // Take the magnitude of the signed speed and clamp it
  always_comb begin
    neg     = speed_i[SPEED_W-1];
    abs_val = neg ? SPEED_W'(~speed_i + 1'b1) : speed_i;
    // the most negative code gives a magnitude of 256 and clamps here
    if (abs_val > MAG_LIMIT) begin
      mag_sat = MAG_LIMIT;
    end else begin
      mag_sat = abs_val;
    end
  end

  // Build the queue entry; zero speed counts as reverse
  always_comb begin
    cmd_o.is_steer = (req_type_i == REQ_STEER);
    cmd_o.steer    = steer_i;
    cmd_o.want_rev = neg || (speed_i == '0);
    cmd_o.mag      = mag_sat[MAG_FIELD_W-1:0];
  end

endmodule

/* src/hbdrv_cmd_fifo.sv */
// Short command queue between the front end and the sequencer.
module hbdrv_cmd_fifo import hbdrv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMD_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_DEPTH - 1);

  cmd_t             mem_q [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/hbdrv_back.sv */
// Back end: register file, drive state and result sequencer with output register.
module hbdrv_back import hbdrv_pkg::*; #(
  parameter int unsigned SPEED_BITS = SPEED_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output res_t                  res_o
);

  localparam int unsigned MAG_W = (SPEED_BITS >= 8) ? 8 : SPEED_BITS;
  localparam int unsigned CMPX_W = CMP_W + 1;

  // Sequencer steps of a speed command
  localparam logic [1:0] ST_ZERO = 2'd0;
  localparam logic [1:0] ST_OFF  = 2'd1;
  localparam logic [1:0] ST_ON   = 2'd2;
  localparam logic [1:0] ST_CMP  = 2'd3;

  logic [TICKS_W-1:0]  thr_q, dead_q;
  logic [RELOAD_W-1:0] left_q, hleft_q, right_q, hright_q, centre_q;

  logic [1:0]          step_q, step_d;
  logic                drv_rev_q, drv_rev_d;
  logic [MAG_W-1:0]    mag_q, mag_d;
  logic [CMP_W-1:0]    fwd_cmp_q, fwd_cmp_d;
  logic [CMP_W-1:0]    rev_cmp_q, rev_cmp_d;
  logic                fwd_en_q, fwd_en_d;
  logic                rev_en_q, rev_en_d;
  logic [RELOAD_W-1:0] servo_q, servo_d;
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;

  logic                fire;
  logic                fast;
  logic [TICKS_W-1:0]  hold;
  logic                last;
  logic [MAG_W-1:0]    new_mag;
  logic [CMPX_W-1:0]   cmp_wide;
  logic [CMP_W-1:0]    cmp_val;

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= SPEED_THR_RST;
      dead_q   <= DEAD_TIME_RST;
      left_q   <= LEFT_RST;
      hleft_q  <= HARD_LEFT_RST;
      right_q  <= RIGHT_RST;
      hright_q <= HARD_RIGHT_RST;
      centre_q <= CENTRE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SPEED_THR:  thr_q    <= cfg_data_i[TICKS_W-1:0];
        REG_DEAD_TIME:  dead_q   <= cfg_data_i[TICKS_W-1:0];
        REG_LEFT:       left_q   <= cfg_data_i;
        REG_HARD_LEFT:  hleft_q  <= cfg_data_i;
        REG_RIGHT:      right_q  <= cfg_data_i;
        REG_HARD_RIGHT: hright_q <= cfg_data_i;
        REG_CENTRE:     centre_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Compare value: magnitude*16 + magnitude/16, clamped
  always_comb begin
    new_mag  = cmd_i.mag[MAG_W-1:0];
    cmp_wide = (CMPX_W'(new_mag) << 4) + (CMPX_W'(new_mag) >> 4);
    cmp_val  = (cmp_wide > CMPX_W'(CMP_MAX)) ? CMP_MAX : cmp_wide[CMP_W-1:0];
    fast     = TICKS_W'(mag_q) > thr_q;
  end

  // A step runs when a command waits and the output slot frees up
  assign fire = cmd_valid_i && (!out_valid_q || res_ready_i);

  // Sequence one result per step
  always_comb begin
    step_d    = step_q;
    drv_rev_d = drv_rev_q;
    mag_d     = mag_q;
    fwd_cmp_d = fwd_cmp_q;
    rev_cmp_d = rev_cmp_q;
    fwd_en_d  = fwd_en_q;
    rev_en_d  = rev_en_q;
    servo_d   = servo_q;
    hold      = '0;
    last      = 1'b0;
    cmd_pop_o = 1'b0;
    if (fire) begin
      if (cmd_i.is_steer) begin
        case (cmd_i.steer)
          STEER_LEFT:   servo_d = fast ? left_q : hleft_q;
          STEER_RIGHT:  servo_d = fast ? right_q : hright_q;
          STEER_CENTRE: servo_d = centre_q;
          default:      servo_d = servo_q;
        endcase
        last      = 1'b1;
        cmd_pop_o = 1'b1;
      end else begin
        case (step_q)
          ST_ZERO: begin
            if (drv_rev_q) begin
              rev_cmp_d = '0;
            end else begin
              fwd_cmp_d = '0;
            end
            step_d = (cmd_i.want_rev != drv_rev_q) ? ST_OFF : ST_CMP;
          end
          ST_OFF: begin
            fwd_en_d = 1'b0;
            rev_en_d = 1'b0;
            step_d   = ST_ON;
          end
          ST_ON: begin
            fwd_en_d  = !cmd_i.want_rev;
            rev_en_d  = cmd_i.want_rev;
            drv_rev_d = cmd_i.want_rev;
            hold      = dead_q;
            step_d    = ST_CMP;
          end
          ST_CMP: begin
            mag_d = new_mag;
            if (drv_rev_q) begin
              rev_cmp_d = cmp_val;
            end else begin
              fwd_cmp_d = cmp_val;
            end
            last      = 1'b1;
            cmd_pop_o = 1'b1;
            step_d    = ST_ZERO;
          end
          default: step_d = ST_ZERO;
        endcase
      end
    end
  end

  // Load the output register with the picture after this step
  always_comb begin
    out_d.fwd_cmp = fwd_cmp_d;
    out_d.rev_cmp = rev_cmp_d;
    out_d.fwd_en  = fwd_en_d;
    out_d.rev_en  = rev_en_d;
    out_d.servo   = servo_d;
    out_d.hold    = hold;
    out_d.last    = last;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_ZERO;
      drv_rev_q   <= 1'b0;
      mag_q       <= '0;
      fwd_cmp_q   <= '0;
      rev_cmp_q   <= '0;
      fwd_en_q    <= 1'b1;
      rev_en_q    <= 1'b0;
      servo_q     <= CENTRE_RST;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      drv_rev_q   <= drv_rev_d;
      mag_q       <= mag_d;
      fwd_cmp_q   <= fwd_cmp_d;
      rev_cmp_q   <= rev_cmp_d;
      fwd_en_q    <= fwd_en_d;
      rev_en_q    <= rev_en_d;
      servo_q     <= servo_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  // Both bridge paths are never on together
  a_no_shoot_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fwd_en_q && rev_en_q))
    else $error("both bridge paths enabled");

  // An enabled path always matches the stored direction
  a_path_matches_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fwd_en_q || rev_en_q) |-> (rev_en_q == drv_rev_q))
    else $error("enabled path disagrees with direction");

  // The idle direction never carries a compare value
  a_idle_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drv_rev_q ? (fwd_cmp_q == '0) : (rev_cmp_q == '0))
    else $error("compare left on idle direction");

  // A speed sequence in progress keeps its command at the queue head
  a_mid_seq_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != ST_ZERO) |-> (cmd_valid_i && !cmd_i.is_steer))
    else $error("sequence running without its command");

endmodule

/* src/hbridge_drive_and_steering_servo.sv */
// Top level of the H-bridge drive and steering servo controller.
// Speed and steering commands enter on the s_axis stream and are queued
// (two entries) ahead of a sequencer that emits the resulting register
// pictures on m_axis, one result item per clock while the output is taken.
// A steering command yields one result; a speed command yields two, or four
// when it reverses the direction (PWM zeroed, both paths off, new path on
// with hold_ticks set to the dead time, new compare value). Results carry
// tlast on the final item of each command. Configuration writes on cfg_*
// are accepted every cycle and are meant to be issued only while no command
// is in flight.
module hbridge_drive_and_steering_servo import hbdrv_pkg::*; #(
  parameter int unsigned SPEED_BITS = SPEED_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // cfg: register index, write data
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // commands
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: speed_command[8:0], steer_command[10:9], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: req_type
  input  logic                  s_axis_tuser_i,
  // results
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: forward_compare[11:0], reverse_compare[23:12], forward_enable[24],
  //        reverse_enable[25], servo_reload[41:26], hold_ticks[49:42], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o
);

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;
  res_t res;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !q_full;
  assign push            = s_axis_tvalid_i && !q_full;

  hbdrv_front #(
    .SPEED_BITS (SPEED_BITS)
  ) u_front (
    .req_type_i (s_axis_tuser_i),
    .speed_i    (s_axis_tdata_i[SPEED_W-1:0]),
    .steer_i    (s_axis_tdata_i[SPEED_W+STEER_W-1:SPEED_W]),
    .cmd_o      (cmd_in)
  );

  hbdrv_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (cmd_head)
  );

  hbdrv_back #(
    .SPEED_BITS (SPEED_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (q_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (q_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Pack the result item
  assign m_axis_tdata_o = {6'b0, res.hold, res.servo, res.rev_en, res.fwd_en,
                           res.rev_cmp, res.fwd_cmp};
  assign m_axis_tlast_o = res.last;

endmodule
